[hdl/psq_pkg.sv]
// psq_pkg: shared types and constants of the priority serve queue.
// Used by psq_store, psq_cmp and priority_serve_queue_core.
`default_nettype none

package psq_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PRIO_W = 16;
    localparam int ORD_W  = 32;
    localparam int ID_W   = 4;

    localparam logic [1:0] OP_ARRIVE = 2'd0;
    localparam logic [1:0] OP_BOOST  = 2'd1;
    localparam logic [1:0] OP_LEAVE  = 2'd2;
    localparam logic [1:0] OP_SERVE  = 2'd3;

    localparam logic [ORD_W-1:0] ORD_MAX = {ORD_W{1'b1}};

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   slot_id;
        logic [PRIO_W-1:0] amount;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]   served_id;
        logic [PRIO_W-1:0] served_priority;
    } t_rsp;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ORD_W-1:0]  order;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic              vset;
        logic              vclr;
        logic [SLOT_W-1:0] vaddr;
        logic [SLOT_W-1:0] raddr;
    } t_store_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BOOST,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

[hdl/psq_store.sv]
// psq_store: slot table memory (priority, arrival number) and slot valid bits.
// Depends on psq_pkg.
`default_nettype none

module psq_store
    import psq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_store_ctl       i_ctl,
    output t_entry                o_rd_data,
    output logic [SLOTS-1:0]      o_valid
);

    t_entry           r_mem [SLOTS];
    t_entry           r_rd_data;
    logic [SLOTS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rd_data <= r_mem[i_ctl.raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.vset) begin
            r_valid[i_ctl.vaddr] <= 1'b1;
        end else if (i_ctl.vclr) begin
            r_valid[i_ctl.vaddr] <= 1'b0;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_valid   = r_valid;

endmodule

`default_nettype wire

[hdl/psq_cmp.sv]
// psq_cmp: shared compare and saturating add unit on the entry read from the table.
// Depends on psq_pkg.
`default_nettype none

module psq_cmp
    import psq_pkg::*;
(
    input  wire t_entry            i_cand,
    input  wire logic              i_cand_valid,
    input  wire t_entry            i_best,
    input  wire logic              i_best_found,
    input  wire logic [PRIO_W-1:0] i_amount,
    output logic                   o_take,
    output logic [PRIO_W-1:0]      o_sum
);

    logic [PRIO_W:0] sum_full;

    always_comb begin
        sum_full = {1'b0, i_cand.prio} + {1'b0, i_amount};
        o_sum    = sum_full[PRIO_W] ? {PRIO_W{1'b1}} : sum_full[PRIO_W-1:0];
        o_take   = i_cand_valid &&
                   (!i_best_found ||
                    (i_cand.prio > i_best.prio) ||
                    ((i_cand.prio == i_best.prio) && (i_cand.order < i_best.order)));
    end

endmodule

`default_nettype wire

[hdl/priority_serve_queue_core.sv]
// priority_serve_queue_core: indexed max-priority slot table with a sequenced scan.
// Arrive, leave and boost of an empty slot complete at acceptance; busy stays low.
// Boost of a valid slot: busy in ST_BOOST (table read at acceptance, then saturating add and write back).
// Serve: busy for the whole scan, one table read per slot through the shared comparator; the
// result strobe comes in the cycle after the last scan cycle, or none if no slot is valid.
// Reset clears the valid bits, the arrival counter and the sequencer; no clearing pass.
`default_nettype none

module priority_serve_queue_core
    import psq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_strobe,
    output t_rsp      o_rsp
);

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_ridx, n_ridx;
    logic [SLOT_W-1:0] r_best, n_best;
    t_entry            r_best_ent, n_best_ent;
    logic              r_found, n_found;
    logic [ORD_W-1:0]  r_cnt, n_cnt;
    logic [PRIO_W-1:0] r_amount, n_amount;
    logic              r_strobe, n_strobe;
    t_rsp              r_rsp, n_rsp;

    t_store_ctl        ctl;
    t_entry            rd_data;
    logic [SLOTS-1:0]  valid;
    logic              take;
    logic [PRIO_W-1:0] sum;
    logic              accept;
    logic              id_ok;
    logic [SLOT_W-1:0] id_addr;
    logic              last;

    psq_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .o_rd_data (rd_data),
        .o_valid   (valid)
    );

    psq_cmp u_cmp (
        .i_cand       (rd_data),
        .i_cand_valid (valid[r_ridx]),
        .i_best       (r_best_ent),
        .i_best_found (r_found),
        .i_amount     (r_amount),
        .o_take       (take),
        .o_sum        (sum)
    );

    assign accept  = start && (r_state == ST_IDLE);
    assign id_ok   = 32'(i_req.slot_id) < SLOTS;
    assign id_addr = SLOT_W'(i_req.slot_id);
    assign last    = (r_ridx == SLOT_W'(SLOTS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.kind == OP_SERVE) begin
                        n_state = ST_SCAN;
                    end else if (i_req.kind == OP_BOOST && id_ok && valid[id_addr]) begin
                        n_state = ST_BOOST;
                    end
                end
            end
            ST_BOOST: n_state = ST_IDLE;
            ST_SCAN: begin
                if (last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl        = '0;
        ctl.raddr  = r_ridx;
        n_ridx     = r_ridx;
        n_best     = r_best;
        n_best_ent = r_best_ent;
        n_found    = r_found;
        n_cnt      = r_cnt;
        n_amount   = r_amount;
        n_strobe   = 1'b0;
        n_rsp      = r_rsp;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_amount = i_req.amount;
                    case (i_req.kind)
                        OP_ARRIVE: begin
                            if (id_ok) begin
                                ctl.we          = 1'b1;
                                ctl.waddr       = id_addr;
                                ctl.wdata.prio  = i_req.amount;
                                ctl.wdata.order = r_cnt;
                                ctl.vset        = 1'b1;
                                ctl.vaddr       = id_addr;
                                if (r_cnt != ORD_MAX) begin
                                    n_cnt = r_cnt + 1'b1;
                                end
                            end
                        end
                        OP_BOOST: begin
                            ctl.raddr = id_addr;
                            n_ridx    = id_addr;
                        end
                        OP_LEAVE: begin
                            if (id_ok) begin
                                ctl.vclr  = 1'b1;
                                ctl.vaddr = id_addr;
                            end
                        end
                        OP_SERVE: begin
                            ctl.raddr = '0;
                            n_ridx    = '0;
                            n_found   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BOOST: begin
                ctl.we          = 1'b1;
                ctl.waddr       = r_ridx;
                ctl.wdata.prio  = sum;
                ctl.wdata.order = rd_data.order;
            end
            ST_SCAN: begin
                ctl.raddr = r_ridx + 1'b1;
                n_ridx    = r_ridx + 1'b1;
                if (take) begin
                    n_best     = r_ridx;
                    n_best_ent = rd_data;
                    n_found    = 1'b1;
                end
                if (last) begin
                    n_strobe              = n_found;
                    n_rsp.served_id       = ID_W'(n_best);
                    n_rsp.served_priority = n_best_ent.prio;
                    ctl.vclr              = n_found;
                    ctl.vaddr             = n_best;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_found  <= n_found;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx     <= n_ridx;
        r_best     <= n_best;
        r_best_ent <= n_best_ent;
        r_amount   <= n_amount;
        r_rsp      <= n_rsp;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

`default_nettype wire
